### src/bnms_pkg.sv
package bnms_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ScoreW = 16;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [ScoreW-1:0] score;
  } box_t;

  typedef struct packed {
    box_t box;
    logic last;
    logic drop;
  } cand_t;

  typedef struct packed {
    box_t box;
    logic last;
    logic ovf;
  } res_t;

endpackage

### src/box_non_maximum_suppression_core.sv
// Greedy IoU non-maximum suppression. Boxes transfer in one per cycle into a
// four-entry queue while it is not full, and are loaded one per cycle into a
// box memory while the back end is in S_LOAD. After the final box, the back
// end repeatedly searches the remaining boxes for the highest score (each box
// read from the box memory in S_SORT, compared in S_PICK), tests it
// against each remaining box (read in S_SCAN, IoU compared in S_CMP1/S_CMP2),
// then presents it, marked last when no box remains; new input is held in
// the queue meanwhile. Results leave through an output register.
module box_non_maximum_suppression_core import bnms_pkg::*; #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] left_edge_i,
  input  logic [15:0] top_edge_i,
  input  logic [15:0] right_edge_i,
  input  logic [15:0] bottom_edge_i,
  input  logic [15:0] confidence_i,
  input  logic        final_box_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] kept_left_o,
  output logic [15:0] kept_top_o,
  output logic [15:0] kept_right_o,
  output logic [15:0] kept_bottom_o,
  output logic [15:0] kept_confidence_o,
  output logic        final_kept_o,
  output logic        dropped_overflow_o
);

  logic [15:0] thr_q;
  logic        qv, qr;
  cand_t       qd;
  res_t        rs;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= 16'd29491;
    else if (cfg_valid_i) thr_q <= cfg_data_i;
  end

  bnms_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_box_i('{left: left_edge_i, top: top_edge_i, right: right_edge_i,
                bottom: bottom_edge_i, score: confidence_i}),
    .in_last_i(final_box_i),
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd)
  );

  bnms_back #(.MaxBoxes(MAX_BOXES)) u_back (
    .clk_i, .rst_ni, .thr_i(thr_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_data_i(qd),
    .out_valid_o, .out_stall_i, .out_data_o(rs)
  );

  assign kept_left_o        = rs.box.left;
  assign kept_top_o         = rs.box.top;
  assign kept_right_o       = rs.box.right;
  assign kept_bottom_o      = rs.box.bottom;
  assign kept_confidence_o  = rs.box.score;
  assign final_kept_o       = rs.last;
  assign dropped_overflow_o = rs.ovf;

endmodule

### src/bnms_front.sv
module bnms_front import bnms_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  box_t  in_box_i,
  input  logic  in_last_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output cand_t q_data_o
);

  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  cand_t      mem_q [4];
  logic       push, pop;

  assign in_stall_o = (cnt_q == 3'd4);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 3'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{box: in_box_i, last: in_last_i, drop: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 2'd1;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

### src/bnms_back.sv
module bnms_back import bnms_pkg::*; #(
  parameter int unsigned MaxBoxes = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ScoreW-1:0] thr_i,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  cand_t             q_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output res_t              out_data_o
);

  localparam int unsigned IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int unsigned CntW = $clog2(MaxBoxes + 1);
  localparam logic [CntW-1:0] Full = CntW'(MaxBoxes);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SORT = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_RDA  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_CMP1 = 3'd6;
  localparam logic [2:0] S_CMP2 = 3'd7;

  logic [2:0]        st_q;
  box_t              mem_q [MaxBoxes];
  logic [MaxBoxes-1:0] done_q;
  logic [CntW-1:0]   n_q;
  logic              ovf_q;
  logic [CntW-1:0]   i_q, j_q;
  logic [IdxW-1:0]   best_q;
  logic [ScoreW-1:0] bsc_q;
  logic              found_q;
  box_t              a_q, rd_q;
  logic              rem_q;
  logic [31:0]       inter_q, uni_q;
  logic              ovl_q;
  logic [47:0]       lhs_q, rhs_q;
  logic              valid_q;
  res_t              out_q;

  logic [IdxW-1:0]   ri;
  logic [CoordW-1:0] ix1, iy1, ix2, iy2, aw, ah, bw, bh;
  logic [31:0]       inter, area_a, area_b;
  logic              more;

  assign q_ready_o   = (st_q == S_LOAD);
  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;
  assign ri          = (st_q == S_PICK || st_q == S_RDA) ? best_q : i_q[IdxW-1:0];
  assign more        = rem_q || (ovl_q && !(lhs_q > rhs_q));

  always_comb begin
    ix1 = (a_q.left > rd_q.left) ? a_q.left : rd_q.left;
    iy1 = (a_q.top > rd_q.top) ? a_q.top : rd_q.top;
    ix2 = (a_q.right < rd_q.right) ? a_q.right : rd_q.right;
    iy2 = (a_q.bottom < rd_q.bottom) ? a_q.bottom : rd_q.bottom;
    aw  = (a_q.right > a_q.left) ? a_q.right - a_q.left : '0;
    ah  = (a_q.bottom > a_q.top) ? a_q.bottom - a_q.top : '0;
    bw  = (rd_q.right > rd_q.left) ? rd_q.right - rd_q.left : '0;
    bh  = (rd_q.bottom > rd_q.top) ? rd_q.bottom - rd_q.top : '0;
    inter  = (ix2 > ix1 && iy2 > iy1) ? 32'(ix2 - ix1) * 32'(iy2 - iy1) : '0;
    area_a = 32'(aw) * 32'(ah);
    area_b = 32'(bw) * 32'(bh);
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_LOAD && q_valid_i && n_q != Full) begin
      mem_q[n_q[IdxW-1:0]] <= q_data_i.box;
    end
    rd_q <= mem_q[ri];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_LOAD;
      done_q  <= '0;
      n_q     <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      best_q  <= '0;
      bsc_q   <= '0;
      found_q <= 1'b0;
      a_q     <= '0;
      rem_q   <= 1'b0;
      inter_q <= '0;
      uni_q   <= '0;
      ovl_q   <= 1'b0;
      lhs_q   <= '0;
      rhs_q   <= '0;
      valid_q <= 1'b0;
      out_q   <= '0;
    end else begin
      if (valid_q && !out_stall_i) valid_q <= 1'b0;
      case (st_q)
        S_LOAD: begin
          if (q_valid_i) begin
            if (n_q != Full) n_q <= n_q + 1'b1;
            else ovf_q <= 1'b1;
            if (q_data_i.last) begin
              st_q    <= S_SORT;
              i_q     <= '0;
              found_q <= 1'b0;
              done_q  <= '0;
              j_q     <= '0;
            end
          end
        end
        S_SORT: begin
          // wait for read of entry i, then compare
          st_q <= S_PICK;
        end
        S_PICK: begin
          if (!done_q[i_q[IdxW-1:0]] && (!found_q || rd_q.score > bsc_q)) begin
            found_q <= 1'b1;
            best_q  <= i_q[IdxW-1:0];
            bsc_q   <= rd_q.score;
          end
          if (i_q + 1'b1 == n_q) begin
            st_q <= S_RDA;
          end else begin
            i_q  <= i_q + 1'b1;
            st_q <= S_SORT;
          end
        end
        S_RDA: begin
          st_q <= S_EMIT;
          j_q  <= '0;
        end
        S_EMIT: begin
          if (!found_q) begin
            st_q  <= S_LOAD;
            n_q   <= '0;
            ovf_q <= 1'b0;
          end else if (j_q == '0) begin
            a_q <= rd_q;
            done_q[best_q] <= 1'b1;
            j_q <= CntW'(1);
          end else if (!valid_q || !out_stall_i) begin
            out_q <= '{box: a_q, last: 1'b0, ovf: ovf_q};
            i_q   <= '0;
            rem_q <= 1'b0;
            j_q   <= '0;
            st_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (j_q == '0) begin
            j_q <= CntW'(1);
          end else begin
            j_q <= '0;
            if (!done_q[i_q[IdxW-1:0]]) begin
              inter_q <= inter;
              uni_q   <= area_a + area_b - inter;
              st_q    <= S_CMP1;
            end else begin
              st_q <= S_CMP2;
              ovl_q <= 1'b0;
              lhs_q <= '0;
              rhs_q <= '1;
            end
          end
        end
        S_CMP1: begin
          lhs_q <= {inter_q, 16'b0};
          rhs_q <= 48'(thr_i) * 48'(uni_q);
          ovl_q <= 1'b1;
          st_q  <= S_CMP2;
        end
        default: begin
          if (ovl_q && lhs_q > rhs_q) begin
            done_q[i_q[IdxW-1:0]] <= 1'b1;
          end else if (ovl_q) begin
            rem_q <= 1'b1;
          end
          ovl_q <= 1'b0;
          if (i_q + 1'b1 == n_q) begin
            // present the held result, last when no box remains
            out_q.last <= !more;
            valid_q    <= 1'b1;
            i_q        <= '0;
            j_q        <= '0;
            found_q    <= 1'b0;
            if (more) begin
              st_q <= S_SORT;
            end else begin
              st_q  <= S_LOAD;
              n_q   <= '0;
              ovf_q <= 1'b0;
            end
          end else begin
            i_q  <= i_q + 1'b1;
            st_q <= S_SCAN;
          end
        end
      endcase
    end
  end

endmodule
